// ===== rtl/sparse_polynomial_term_table_assert.svh =====
// ----------------------------------------------------------------------------
// sparse_polynomial_term_table_assert
// Assertion macros used by the term table top level. Each macro expands to one
// labeled concurrent assertion clocked on the rising edge and disabled while
// reset is high.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_TERM_TABLE_ASSERT_SVH
`define SPARSE_POLYNOMIAL_TERM_TABLE_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SPT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define SPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== rtl/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and default sizes for the sparse polynomial term table.
// ----------------------------------------------------------------------------
package spt_pkg;

   localparam int MAX_TERMS_DEF  = 16;
   localparam int POWER_BITS_DEF = 8;
   localparam int COEFF_BITS_DEF = 32;

   // Operation codes carried in the request tuser
   typedef enum logic [1:0] {
      FUNC_SET  = 2'd0,
      FUNC_READ = 2'd1,
      FUNC_ADD  = 2'd2,
      FUNC_SUB  = 2'd3
   } func_type;

   // Result status carried in the response tuser
   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_FULL   = 2'd2
   } status_type;

   // Decoded operation handed from the front end to the engine
   typedef struct packed {
      logic is_read;
      logic is_set;
      logic is_sub;
   } op_ctl_type;

endpackage

// ===== rtl/sparse_polynomial_term_table.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_term_table
// Sparse polynomial kept as a sorted table of nonzero Q16.16 terms, with set,
// read, add and subtract operations and one response per request.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req_*    in         tuser: func; tdata: term_power, term_coeff
//  rsp_*    out        tuser: status; tdata: coeff_out, poly_degree, term_count
//
//  The engine handles one item at a time: a linear search scans the stored
//  entries, then an insert or delete moves entries, both through the single
//  read and single write port of the term memory, and an insert also writes
//  the new term. Reset is synchronous and empties the table at once; no
//  clearing pass. A two-entry queue keeps taking requests while the engine
//  works, until both entries are held, and the response register lets the
//  next item start while a result waits.
// ----------------------------------------------------------------------------
`include "sparse_polynomial_term_table_assert.svh"

module sparse_polynomial_term_table
   import spt_pkg::*;
#(
   parameter int MAX_TERMS  = MAX_TERMS_DEF,
   parameter int POWER_BITS = POWER_BITS_DEF,
   parameter int COEFF_BITS = COEFF_BITS_DEF,
   localparam int CNT_W     = $clog2(MAX_TERMS + 1),
   localparam int REQ_W     = ((POWER_BITS + COEFF_BITS + 7) / 8) * 8,
   localparam int RSP_W     = ((COEFF_BITS + POWER_BITS + CNT_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // term_power, term_coeff (from bit 0 up)
   input  logic [REQ_W-1:0] req_tdata,
   // func
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // coeff_out, poly_degree, term_count (from bit 0 up)
   output logic [RSP_W-1:0] rsp_tdata,
   // status
   output logic [1:0]       rsp_tuser
);

   op_ctl_type            cmd_ctl;
   logic                  cmd_valid, cmd_ready;
   logic [POWER_BITS-1:0] cmd_power;
   logic [COEFF_BITS-1:0] cmd_coeff;
   logic                  eng_valid, eng_ready;
   logic [COEFF_BITS-1:0] eng_coeff;
   logic [POWER_BITS-1:0] eng_degree;
   logic [CNT_W-1:0]      eng_count;
   status_type            eng_status;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COEFF_BITS-1:0] rsp_coeff_ff, rsp_coeff_in;
   logic [POWER_BITS-1:0] rsp_degree_ff, rsp_degree_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   status_type            rsp_status_ff, rsp_status_in;

   spt_front #(
      .POWER_BITS (POWER_BITS),
      .COEFF_BITS (COEFF_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (req_tuser),
      .req_power (req_tdata[POWER_BITS-1:0]),
      .req_coeff (req_tdata[POWER_BITS +: COEFF_BITS]),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_ctl   (cmd_ctl),
      .cmd_power (cmd_power),
      .cmd_coeff (cmd_coeff)
   );

   spt_engine #(
      .MAX_TERMS  (MAX_TERMS),
      .POWER_BITS (POWER_BITS),
      .COEFF_BITS (COEFF_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_ctl    (cmd_ctl),
      .cmd_power  (cmd_power),
      .cmd_coeff  (cmd_coeff),
      .res_valid  (eng_valid),
      .res_ready  (eng_ready),
      .res_coeff  (eng_coeff),
      .res_degree (eng_degree),
      .res_count  (eng_count),
      .res_status (eng_status)
   );

   // Response register: load when empty or being drained
   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_coeff_in  = rsp_coeff_ff;
      rsp_degree_in = rsp_degree_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (eng_ready) begin
         rsp_valid_in  = eng_valid;
         rsp_coeff_in  = eng_coeff;
         rsp_degree_in = eng_degree;
         rsp_count_in  = eng_count;
         rsp_status_in = eng_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_coeff_ff  <= rsp_coeff_in;
      rsp_degree_ff <= rsp_degree_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_degree_ff, rsp_coeff_ff});
   assign rsp_tuser  = rsp_status_ff;

   // A full table reports exactly MAX_TERMS stored terms
   `SPT_ASSERT_IMPL(a_full_count, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STAT_FULL), rsp_count_ff == CNT_W'(MAX_TERMS))
   // An empty table reports degree zero
   `SPT_ASSERT_IMPL(a_empty_degree, clock, reset,
      rsp_valid_ff && (rsp_count_ff == '0), rsp_degree_ff == '0)
   // A rejected zero for an absent term reports coefficient zero
   `SPT_ASSERT_IMPL(a_reject_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STAT_REJECT), rsp_coeff_ff == '0)
   // A result handed over by the engine shows up at the response port
   `SPT_ASSERT_NEXT(a_result_lands, clock, reset,
      eng_valid && eng_ready, rsp_valid_ff)

endmodule

// ===== rtl/spt_front.sv =====
// ----------------------------------------------------------------------------
// spt_front
// Accepts request items, decodes the operation and buffers them in a
// two-entry queue in front of the engine.
// ----------------------------------------------------------------------------
module spt_front
   import spt_pkg::*;
#(
   parameter int POWER_BITS = POWER_BITS_DEF,
   parameter int COEFF_BITS = COEFF_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [POWER_BITS-1:0] req_power,
   input  logic [COEFF_BITS-1:0] req_coeff,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output op_ctl_type            cmd_ctl,
   output logic [POWER_BITS-1:0] cmd_power,
   output logic [COEFF_BITS-1:0] cmd_coeff
);

   op_ctl_type            q_ctl_ff   [2];
   logic [POWER_BITS-1:0] q_power_ff [2];
   logic [COEFF_BITS-1:0] q_coeff_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;
   op_ctl_type            dec_ctl;
   logic                  push, pop;

   // Decode the operation code
   always_comb begin
      dec_ctl = '0;
      case (func_type'(req_func))
         FUNC_SET:  dec_ctl.is_set  = 1'b1;
         FUNC_READ: dec_ctl.is_read = 1'b1;
         FUNC_ADD:  dec_ctl.is_sub  = 1'b0;
         FUNC_SUB:  dec_ctl.is_sub  = 1'b1;
         default:   dec_ctl = '0;
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;

   assign cmd_ctl   = q_ctl_ff[rd_ptr_ff];
   assign cmd_power = q_power_ff[rd_ptr_ff];
   assign cmd_coeff = q_coeff_ff[rd_ptr_ff];

   // Advance queue pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the decoded item
   always_ff @(posedge clock) begin
      if (push) begin
         q_ctl_ff[wr_ptr_ff]   <= dec_ctl;
         q_power_ff[wr_ptr_ff] <= req_power;
         q_coeff_ff[wr_ptr_ff] <= req_coeff;
      end
   end

endmodule

// ===== rtl/spt_engine.sv =====
// ----------------------------------------------------------------------------
// spt_engine
// Executes one operation at a time on the sorted term memory: linear search, a set
// or saturating add or subtract, then an in-place write or a shifting insert or delete one entry per cycle.
// ----------------------------------------------------------------------------
module spt_engine
   import spt_pkg::*;
#(
   parameter int MAX_TERMS  = MAX_TERMS_DEF,
   parameter int POWER_BITS = POWER_BITS_DEF,
   parameter int COEFF_BITS = COEFF_BITS_DEF,
   localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
   localparam int CNT_W     = $clog2(MAX_TERMS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  op_ctl_type            cmd_ctl,
   input  logic [POWER_BITS-1:0] cmd_power,
   input  logic [COEFF_BITS-1:0] cmd_coeff,
   output logic                  res_valid,
   input  logic                  res_ready,
   output logic [COEFF_BITS-1:0] res_coeff,
   output logic [POWER_BITS-1:0] res_degree,
   output logic [CNT_W-1:0]      res_count,
   output status_type            res_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_SHIFT,
      ST_PUT,
      ST_DONE
   } state_type;

   localparam logic [COEFF_BITS-1:0] COEFF_MAX = {1'b0, {(COEFF_BITS-1){1'b1}}};
   localparam logic [COEFF_BITS-1:0] COEFF_MIN = {1'b1, {(COEFF_BITS-1){1'b0}}};

   // Term memory
   logic [POWER_BITS-1:0] mem_power_ff [MAX_TERMS];
   logic [COEFF_BITS-1:0] mem_coeff_ff [MAX_TERMS];
   logic [POWER_BITS-1:0] rd_power_ff;
   logic [COEFF_BITS-1:0] rd_coeff_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [POWER_BITS-1:0] wr_power;
   logic [COEFF_BITS-1:0] wr_coeff;

   state_type             state_ff, state_in;
   op_ctl_type            ctl_ff, ctl_in;
   logic [POWER_BITS-1:0] power_ff, power_in;
   logic [COEFF_BITS-1:0] coeff_ff, coeff_in;
   logic [COEFF_BITS-1:0] cur_ff, cur_in;
   logic [COEFF_BITS-1:0] target_ff, target_in;
   logic                  found_ff, found_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [IDX_W-1:0]      src_ff, src_in;
   logic [IDX_W-1:0]      pend_ff, pend_in;
   logic [IDX_W-1:0]      lim_ff, lim_in;
   logic                  more_ff, more_in;
   logic                  down_ff, down_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [POWER_BITS-1:0] deg_ff, deg_in;
   status_type            status_ff, status_in;

   logic [IDX_W-1:0]      last_idx;
   logic [IDX_W-1:0]      pos_idx;
   logic [COEFF_BITS:0]   cur_x, opnd_x, sum_x;
   logic [COEFF_BITS-1:0] sat_val;
   logic [COEFF_BITS-1:0] target;

   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign pos_idx  = pos_ff[IDX_W-1:0];

   // Saturating add or subtract of the operand to the current coefficient
   always_comb begin
      cur_x  = {cur_ff[COEFF_BITS-1], cur_ff};
      opnd_x = {coeff_ff[COEFF_BITS-1], coeff_ff};
      sum_x  = ctl_ff.is_sub ? (cur_x - opnd_x) : (cur_x + opnd_x);
      if (sum_x[COEFF_BITS] != sum_x[COEFF_BITS-1]) begin
         sat_val = sum_x[COEFF_BITS] ? COEFF_MIN : COEFF_MAX;
      end else begin
         sat_val = sum_x[COEFF_BITS-1:0];
      end
      target = ctl_ff.is_set ? coeff_ff : sat_val;
   end

   // Sequencer next state
   always_comb begin
      state_in  = state_ff;
      ctl_in    = ctl_ff;
      power_in  = power_ff;
      coeff_in  = coeff_ff;
      cur_in    = cur_ff;
      target_in = target_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      scan_in   = scan_ff;
      src_in    = src_ff;
      pend_in   = pend_ff;
      lim_in    = lim_ff;
      more_in   = more_ff;
      down_in   = down_ff;
      count_in  = count_ff;
      status_in = status_ff;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_power  = rd_power_ff;
      wr_coeff  = rd_coeff_ff;
      cmd_ready = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Take the next item and start the scan at the head
            if (cmd_valid) begin
               cmd_ready = 1'b1;
               ctl_in    = cmd_ctl;
               power_in  = cmd_power;
               coeff_in  = cmd_coeff;
               cur_in    = '0;
               found_in  = 1'b0;
               pos_in    = count_ff;
               scan_in   = '0;
               status_in = STAT_OK;
               state_in  = (count_ff == '0) ? ST_DECIDE : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Entries are sorted descending: stop at a match or a smaller power
            if (rd_power_ff == power_ff) begin
               found_in = 1'b1;
               cur_in   = rd_coeff_ff;
               pos_in   = CNT_W'(scan_ff);
               state_in = ST_DECIDE;
            end else if (rd_power_ff < power_ff) begin
               pos_in   = CNT_W'(scan_ff);
               state_in = ST_DECIDE;
            end else if (scan_ff == last_idx) begin
               state_in = ST_DECIDE;
            end else begin
               rd_addr = IDX_W'(scan_ff + 1'b1);
               scan_in = IDX_W'(scan_ff + 1'b1);
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            if (ctl_ff.is_read) begin
               // Read leaves the table alone
               state_in = ST_DONE;
            end else if (found_ff) begin
               if (target == '0) begin
                  // Remove the term; close the gap from above
                  cur_in   = '0;
                  count_in = count_ff - CNT_W'(1);
                  if (pos_idx != last_idx) begin
                     rd_addr  = IDX_W'(pos_idx + 1'b1);
                     pend_in  = IDX_W'(pos_idx + 1'b1);
                     src_in   = IDX_W'(pos_idx + 2'd2);
                     lim_in   = last_idx;
                     more_in  = (IDX_W'(pos_idx + 1'b1) != last_idx);
                     down_in  = 1'b1;
                     state_in = ST_SHIFT;
                  end
               end else begin
                  // Overwrite the coefficient in place
                  wr_en    = 1'b1;
                  wr_addr  = pos_idx;
                  wr_power = power_ff;
                  wr_coeff = target;
                  cur_in   = target;
               end
            end else if (target == '0) begin
               status_in = STAT_REJECT;
            end else if (count_ff == CNT_W'(MAX_TERMS)) begin
               status_in = STAT_FULL;
            end else begin
               target_in = target;
               if (pos_ff == count_ff) begin
                  state_in = ST_PUT;
               end else begin
                  // Open a slot: move entries up starting from the tail
                  rd_addr  = last_idx;
                  pend_in  = last_idx;
                  src_in   = IDX_W'(last_idx - 1'b1);
                  lim_in   = pos_idx;
                  more_in  = (last_idx != pos_idx);
                  down_in  = 1'b0;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // Write back the entry read last cycle, read the next one while any remain
            wr_en   = 1'b1;
            wr_addr = down_ff ? IDX_W'(pend_ff - 1'b1) : IDX_W'(pend_ff + 1'b1);
            if (more_ff) begin
               rd_addr = src_ff;
               pend_in = src_ff;
               src_in  = down_ff ? IDX_W'(src_ff + 1'b1) : IDX_W'(src_ff - 1'b1);
               more_in = (src_ff != lim_ff);
            end else begin
               state_in = down_ff ? ST_DONE : ST_PUT;
            end
         end
         ST_PUT: begin
            // Drop the new term into its slot
            wr_en    = 1'b1;
            wr_addr  = pos_idx;
            wr_power = power_ff;
            wr_coeff = target_ff;
            cur_in   = target_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Track the head power as the degree
   always_comb begin
      deg_in = deg_ff;
      if (wr_en && (wr_addr == '0)) begin
         deg_in = wr_power;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         status_ff <= STAT_OK;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
      ctl_ff    <= ctl_in;
      power_ff  <= power_in;
      coeff_ff  <= coeff_in;
      cur_ff    <= cur_in;
      target_ff <= target_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      scan_ff   <= scan_in;
      src_ff    <= src_in;
      pend_ff   <= pend_in;
      lim_ff    <= lim_in;
      more_ff   <= more_in;
      down_ff   <= down_in;
      deg_ff    <= deg_in;
   end

   // Term memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_power_ff[wr_addr] <= wr_power;
         mem_coeff_ff[wr_addr] <= wr_coeff;
      end
      rd_power_ff <= mem_power_ff[rd_addr];
      rd_coeff_ff <= mem_coeff_ff[rd_addr];
   end

   assign res_coeff  = cur_ff;
   assign res_count  = count_ff;
   assign res_degree = (count_ff == '0) ? '0 : deg_ff;
   assign res_status = status_ff;

endmodule

// ===== tb/tb_sparse_polynomial_term_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_term_table
// Self-checking bench for the sorted sparse polynomial term table. A
// scoreboard keeps its own sorted copy of the terms, predicts coefficient,
// degree, term count and status for each accepted request, and compares every
// response in order. Directed corner items come first, then random traffic
// over small and full power ranges under three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_term_table;
   import spt_pkg::*;

   localparam int  CNT_W   = $clog2(MAX_TERMS_DEF + 1);
   localparam int  REQ_W   = ((POWER_BITS_DEF + COEFF_BITS_DEF + 7) / 8) * 8;
   localparam int  RSP_W   = ((COEFF_BITS_DEF + POWER_BITS_DEF + CNT_W + 7) / 8) * 8;
   localparam longint COEFF_MAX = 64'sd2147483647;
   localparam longint COEFF_MIN = -64'sd2147483648;
   localparam int  RANDOM_ITEMS = 1750;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;

   int idle_pct  = 0;
   int stall_pct = 0;

   // Scoreboard: sorted term copy plus queue of predicted responses
   class term_table_scoreboard;
      typedef struct {
         logic signed [31:0] coeff;
         logic [7:0]         degree;
         logic [4:0]         count;
         status_type         status;
      } term_result_type;

      logic [7:0]         term_pow[MAX_TERMS_DEF];
      logic signed [31:0] term_val[MAX_TERMS_DEF];
      int                 n_terms;
      term_result_type    result_q[$];
      int                 error_count;

      function new();
         n_terms     = 0;
         error_count = 0;
      endfunction

      function int find_slot(logic [7:0] p);
         for (int i = 0; i < n_terms; i++)
            if (term_pow[i] == p) return i;
         return -1;
      endfunction

      function logic signed [31:0] coeff_of(logic [7:0] p);
         int idx;
         idx = find_slot(p);
         return (idx >= 0) ? term_val[idx] : 32'sd0;
      endfunction

      function int pending();
         return result_q.size();
      endfunction

      // Apply one accepted request and queue the response it must produce
      function void note_request(func_type f, logic [7:0] p, logic signed [31:0] c);
         int              idx;
         int              pos;
         longint          cur;
         longint          sum;
         term_result_type res;
         idx = find_slot(p);
         cur = (idx >= 0) ? longint'(term_val[idx]) : 0;
         res.status = STAT_OK;
         if (f != FUNC_READ) begin
            case (f)
               FUNC_SET: sum = longint'(c);
               FUNC_ADD: sum = cur + longint'(c);
               default:  sum = cur - longint'(c);
            endcase
            if (sum > COEFF_MAX) sum = COEFF_MAX;
            if (sum < COEFF_MIN) sum = COEFF_MIN;
            if (idx >= 0) begin
               if (sum == 0) begin
                  // drop the term and close the gap
                  for (int k = idx; k < n_terms - 1; k++) begin
                     term_pow[k] = term_pow[k + 1];
                     term_val[k] = term_val[k + 1];
                  end
                  n_terms--;
                  cur = 0;
               end else begin
                  term_val[idx] = sum[31:0];
                  cur = sum;
               end
            end else if (sum == 0) begin
               res.status = STAT_REJECT;
            end else if (n_terms >= MAX_TERMS_DEF) begin
               res.status = STAT_FULL;
            end else begin
               // insert keeping descending power order
               pos = 0;
               while (pos < n_terms && term_pow[pos] > p) pos++;
               for (int k = n_terms; k > pos; k--) begin
                  term_pow[k] = term_pow[k - 1];
                  term_val[k] = term_val[k - 1];
               end
               term_pow[pos] = p;
               term_val[pos] = sum[31:0];
               n_terms++;
               cur = sum;
            end
         end
         res.coeff  = cur[31:0];
         res.degree = (n_terms > 0) ? term_pow[0] : 8'd0;
         res.count  = n_terms[4:0];
         result_q.push_back(res);
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_result(logic [RSP_W-1:0] data, logic [1:0] user);
         term_result_type want;
         if (result_q.size() == 0) begin
            $error("unexpected response item: coeff_out %0d", $signed(data[31:0]));
            error_count++;
            return;
         end
         want = result_q.pop_front();
         if (data[31:0] !== want.coeff) begin
            $error("coeff_out: expected %0d, got %0d", want.coeff, $signed(data[31:0]));
            error_count++;
         end
         if (data[39:32] !== want.degree) begin
            $error("poly_degree: expected %0d, got %0d", want.degree, data[39:32]);
            error_count++;
         end
         if (data[44:40] !== want.count) begin
            $error("term_count: expected %0d, got %0d", want.count, data[44:40]);
            error_count++;
         end
         if (user !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, user);
            error_count++;
         end
      endfunction
   endclass

   term_table_scoreboard terms_sb = new();

   sparse_polynomial_term_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Present one request, with random idle cycles ahead of it, and hold it
   // until accepted
   task automatic send_term(func_type f, logic [7:0] p, logic signed [31:0] c);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= REQ_W'({c, p});
      do @(posedge clock); while (!req_tready);
      terms_sb.note_request(f, p, c);
   endtask

   // Pick a random request biased toward hits, cancellations and saturation
   task automatic random_term(int pool_top);
      func_type           f;
      logic [7:0]         p;
      logic signed [31:0] c;
      logic signed [31:0] cur;
      f = func_type'($urandom_range(3));
      p = ($urandom_range(99) < 15) ? 8'($urandom_range(255)) : 8'($urandom_range(pool_top));
      cur = terms_sb.coeff_of(p);
      case ($urandom_range(9))
         0: c = 32'sd0;
         1: c = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: begin
            // cancel the stored coefficient so the term drops out
            if (f == FUNC_ADD)      c = -cur;
            else if (f == FUNC_SUB) c = cur;
            else                    c = 32'sd0;
         end
         3, 4: c = $urandom_range(1) ? 32'($urandom_range(1 << 17))
                                     : -32'($urandom_range(1 << 17));
         default: c = $urandom;
      endcase
      send_term(f, p, c);
   endtask

   // Response side: random stalls, check every accepted item
   initial begin
      forever begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            terms_sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Main sequence
   initial begin
      int pool_top;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct  = 24;
      stall_pct = 88;

      // empty table: read, and zero values for absent terms
      send_term(FUNC_READ, 8'd0, $urandom);
      send_term(FUNC_SET, 8'd5, 32'sd0);
      send_term(FUNC_ADD, 8'd7, 32'sd0);
      send_term(FUNC_SUB, 8'd9, 32'sd0);
      // subtracting the most negative value from an absent term
      send_term(FUNC_SUB, 8'd0, 32'sh8000_0000);
      send_term(FUNC_ADD, 8'd0, 32'sd1);
      send_term(FUNC_SET, 8'd255, 32'sh8000_0000);
      send_term(FUNC_SUB, 8'd255, 32'sd1);
      send_term(FUNC_ADD, 8'd255, 32'sh7FFF_FFFF);
      // sum reaches zero: term removed
      send_term(FUNC_ADD, 8'd255, 32'sd1);
      send_term(FUNC_SET, 8'd0, 32'sd0);
      send_term(FUNC_READ, 8'd0, $urandom);
      // fill the table, then try a new term and a zero on a full table
      for (int k = 0; k < MAX_TERMS_DEF; k++)
         send_term(FUNC_SET, 8'(k * 17), $urandom | 32'd1);
      send_term(FUNC_SET, 8'd100, 32'sd5);
      send_term(FUNC_ADD, 8'd100, 32'sd0);
      send_term(FUNC_SET, 8'd34, 32'sd0);

      // random traffic under three idle/stall profiles
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct  = (ph == 0) ? 24 : (ph == 1) ? 88 : 0;
         stall_pct = (ph == 0) ? 88 : (ph == 1) ? 24 : 0;
         pool_top  = 11;
         for (int n = 0; n < RANDOM_ITEMS / 3 + 1; n++) begin
            if (n % 64 == 0) begin
               case ($urandom_range(2))
                  0:       pool_top = 3;
                  1:       pool_top = 11;
                  default: pool_top = 23;
               endcase
            end
            random_term(pool_top);
         end
      end
      req_tvalid <= 1'b0;

      // drain and let any stray response show up
      while (terms_sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (terms_sb.error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
